### src/bmpq_pkg.sv
// ----------------------------------------------------------------------------
// bmpq_pkg
// Shared types and constants for the bounded minimum priority queue.
// ----------------------------------------------------------------------------
package bmpq_pkg;

	localparam int CAPACITY = 128;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int PLD_W    = 64;
	localparam int HELD_W   = 8;

	localparam logic [PLD_W-1:0] EMPTY_PAYLOAD = 64'hFFF0_0000_0000_0000;

	typedef enum logic {
		CMD_INSERT  = 1'b0,
		CMD_EXTRACT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PLD_W-1:0]        payload;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic extract;
	} cell_ctrl_t;

endpackage

### src/bounded_min_priority_queue.sv
// ----------------------------------------------------------------------------
// bounded_min_priority_queue
// Sorted queue of signed keys with payloads, smallest key leaves first.
// ----------------------------------------------------------------------------
// Input requests arrive on the s_axis group: tuser selects insert (0) or
// extract (1), tdata carries the key and the payload for an insert.
// Every request gives exactly one result on the m_axis group: tuser is the
// status (ok, full, empty), tdata the extracted payload and the count held.
// A row of CAPACITY cells keeps the entries in ascending key order; every
// cell compares its key with the incoming one in the same cycle and then
// holds, takes the new entry or shifts one place, so a request may be
// accepted on every clock edge while the output register is free or being taken.
// The result is registered: it appears in the cycle after acceptance and stays
// until taken. While the receiver stalls a full output register, s_axis_tready
// is low; it is high again in the cycle the result is taken.
// Reset empties the queue at once; the cell contents are not cleared, only
// the occupancy count, so no sweep is needed after reset.
// ----------------------------------------------------------------------------
module bounded_min_priority_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [0:0]   s_axis_tuser,   // command
	input  logic [95:0]  s_axis_tdata,   // entry_key, payload_in
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [1:0]   m_axis_tuser,   // status
	output logic [71:0]  m_axis_tdata    // min_payload, entries_held
);
	import bmpq_pkg::*;

	logic [CNT_W-1:0] occ_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [PLD_W-1:0] payload_q;
	logic [HELD_W-1:0] held_q;

	logic       s_fire;
	logic       is_extract;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;
	entry_t     new_entry;
	entry_t     entry_w [CAPACITY];
	logic       keep_w  [CAPACITY];
	logic [CNT_W-1:0] occ_next;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign is_extract    = (cmd_t'(s_axis_tuser[0]) == CMD_EXTRACT);
	assign full          = (occ_q == CNT_W'(CAPACITY));
	assign empty         = (occ_q == '0);

	assign new_entry.key     = s_axis_tdata[KEY_W-1:0];
	assign new_entry.payload = s_axis_tdata[KEY_W +: PLD_W];

	assign ctrl.insert  = s_fire && !is_extract && !full;
	assign ctrl.extract = s_fire && is_extract && !empty;

	always_comb begin
		occ_next = occ_q;
		if (ctrl.insert) begin
			occ_next = occ_q + 1'b1;
		end else if (ctrl.extract) begin
			occ_next = occ_q - 1'b1;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_entry;
		entry_t right_entry;
		logic   left_keeps;
		logic   occupied;

		assign occupied = (CNT_W'(i) < occ_q);

		if (i == 0) begin : g_first
			assign left_entry = new_entry;
			assign left_keeps = 1'b1;
		end else begin : g_mid
			assign left_entry = entry_w[i-1];
			assign left_keeps = keep_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entry_w[i];
		end else begin : g_body
			assign right_entry = entry_w[i+1];
		end

		bmpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occupied),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.left_keeps  (left_keeps),
			.right_entry (right_entry),
			.entry       (entry_w[i]),
			.keeps       (keep_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_next;
			if (s_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			held_q <= HELD_W'(occ_next);
			if (is_extract) begin
				status_q  <= empty ? ST_EMPTY : ST_OK;
				payload_q <= empty ? EMPTY_PAYLOAD : entry_w[0].payload;
			end else begin
				status_q  <= full ? ST_FULL : ST_OK;
				payload_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {held_q, payload_q};

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	a_extract_count: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && is_extract && !empty |=> occ_q == $past(occ_q) - 1'b1
			&& m_axis_tuser == ST_OK)
		else $error("extract did not remove one entry");

	a_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !is_extract && full |=> m_axis_tuser == ST_FULL
			&& occ_q == $past(occ_q) && m_axis_tdata[PLD_W-1:0] == '0)
		else $error("insert on full queue changed state");

	a_extract_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && is_extract && empty |=> m_axis_tuser == ST_EMPTY
			&& m_axis_tdata[PLD_W-1:0] == EMPTY_PAYLOAD && occ_q == '0)
		else $error("extract on empty queue gave wrong result");

endmodule

### src/bmpq_cell.sv
// ----------------------------------------------------------------------------
// bmpq_cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module bmpq_cell (
	input  logic                clk,
	input  bmpq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  bmpq_pkg::entry_t    new_entry,
	input  bmpq_pkg::entry_t    left_entry,
	input  logic                left_keeps,
	input  bmpq_pkg::entry_t    right_entry,
	output bmpq_pkg::entry_t    entry,
	output logic                keeps
);
	import bmpq_pkg::*;

	entry_t entry_q;

	// stays in place when it sorts at or before the new key
	assign keeps = occupied && (entry_q.key <= new_entry.key);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!keeps) begin
				entry_q <= left_keeps ? new_entry : left_entry;
			end
		end else if (ctrl.extract) begin
			entry_q <= right_entry;
		end
	end

endmodule
